[src/tawru_pkg.sv]
// shared types and constants for the tcp ack, window and rtt update unit
// no dependencies
`timescale 1ns / 1ps

package tawru_pkg;

  localparam int SEQ_W    = 32;
  localparam int RTT_W    = 32;
  localparam int WIN_W    = 16;
  localparam int GAIN_W   = 9;
  localparam int OFFSET_W = 16;
  localparam int KIND_W   = 2;
  localparam int DUP_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 9'd256;
  localparam logic [DUP_W-1:0]  DUP_THRESHOLD = 2'd3;
  localparam logic [WIN_W-1:0]  WIN_MAX = 16'hFFFF;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STALE      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NEW_ACK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUPLICATE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RETRANSMIT = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_OFS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SSTHRESH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WINDOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SEQ    = 3'd5;

  // rtt estimator state
  typedef struct packed {
    logic [RTT_W-1:0] srtt;
    logic [RTT_W-1:0] rttvar;
  } rtt_est_t;

endpackage

[src/tawru_rtt_calc.sv]
// jacobson rtt estimator next-value logic, combinational
// depends on tawru_pkg
`timescale 1ns / 1ps

module tawru_rtt_calc (
  input  logic [31:0]              rtt_sample,
  input  logic                     seeded,
  input  tawru_pkg::rtt_est_t      est_cur,
  input  logic [8:0]               alpha_gain,
  input  logic [8:0]               beta_gain,
  input  logic [15:0]              variance_offset,
  output tawru_pkg::rtt_est_t      est_next
);
  import tawru_pkg::*;

  logic [GAIN_W-1:0] alpha_c;
  logic [GAIN_W-1:0] beta_c;
  logic [GAIN_W-1:0] alpha_keep;
  logic [GAIN_W-1:0] beta_keep;
  logic [RTT_W-1:0]  delta;
  logic [RTT_W+8:0]  var_old_term;
  logic [RTT_W+8:0]  var_new_term;
  logic [RTT_W+8:0]  var_sum;
  logic [RTT_W+1:0]  var_ofs;
  logic [RTT_W+8:0]  srtt_old_term;
  logic [RTT_W+8:0]  srtt_new_term;
  logic [RTT_W+8:0]  srtt_sum;

  // a gain above 1.0 acts as 1.0
  assign alpha_c    = alpha_gain[GAIN_W-1] ? GAIN_ONE : alpha_gain;
  assign beta_c     = beta_gain[GAIN_W-1]  ? GAIN_ONE : beta_gain;
  assign alpha_keep = GAIN_ONE - alpha_c;
  assign beta_keep  = GAIN_ONE - beta_c;

  assign delta = (est_cur.srtt > rtt_sample) ? (est_cur.srtt - rtt_sample)
                                             : (rtt_sample - est_cur.srtt);

  // weights sum to 256, so the sums never carry out of 41 bits
  assign var_old_term  = (RTT_W+9)'(beta_keep)  * (RTT_W+9)'(est_cur.rttvar);
  assign var_new_term  = (RTT_W+9)'(beta_c)     * (RTT_W+9)'(delta);
  assign var_sum       = var_old_term + var_new_term;
  assign var_ofs       = {1'b0, var_sum[RTT_W+8:8]} + (RTT_W+2)'(variance_offset);

  assign srtt_old_term = (RTT_W+9)'(alpha_keep) * (RTT_W+9)'(est_cur.srtt);
  assign srtt_new_term = (RTT_W+9)'(alpha_c)    * (RTT_W+9)'(rtt_sample);
  assign srtt_sum      = srtt_old_term + srtt_new_term;

  always_comb begin
    if (!seeded) begin
      est_next.srtt   = rtt_sample;
      est_next.rttvar = {1'b0, rtt_sample[RTT_W-1:1]};
    end else begin
      est_next.srtt   = srtt_sum[RTT_W+7:8];
      est_next.rttvar = (|var_ofs[RTT_W+1:RTT_W]) ? {RTT_W{1'b1}} : var_ofs[RTT_W-1:0];
    end
  end

endmodule

[src/tcp_ack_window_rtt_update_unit.sv]
// top level: tcp ack classification, congestion window and rtt estimator
// depends on tawru_pkg and tawru_rtt_calc
`timescale 1ns / 1ps

// Takes ack transfers (ack number plus rtt sample) and returns one result
// transfer per ack. An ack is classified against the oldest unacked sequence
// with modulo 2^32 compare: a new ack releases entries, grows the window
// (by the gap in slow start, by one at or above the threshold) and updates
// the smoothed rtt and variance with Q1.8 gains; a repeat of the last new
// ack is counted and from the third on asks for a retransmit of ack+1 and
// adds one to the window; anything else is stale. An ack passes the input
// register, then the result register; while out_stall is low the sustained
// rate is one ack per cycle: all state is updated by a single pass through
// the classifier, window adder and the estimator's two 9x32 multiply pairs.
// The input side keeps taking transfers while a result waits on a stalled
// output, up to one held ack. The user must write configuration only while
// idle, not enforced by the block; writing initial_window or initial_sequence
// loads the live window or oldest unacked sequence at once.

module tcp_ack_window_rtt_update_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write_enable,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // ack input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] ack_number,
  input  logic [31:0] rtt_sample,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  ack_kind,
  output logic [31:0] retransmit_sequence,
  output logic [15:0] released_count,
  output logic [31:0] oldest_unacked,
  output logic [15:0] window_now,
  output logic [31:0] smoothed_rtt,
  output logic [31:0] rtt_variance
);
  import tawru_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]   alpha_gain;
  logic [GAIN_W-1:0]   beta_gain;
  logic [OFFSET_W-1:0] variance_offset;
  logic [WIN_W-1:0]    slow_start_threshold;

  // connection state
  logic [SEQ_W-1:0]    unacked_base;
  logic [SEQ_W-1:0]    last_ack_seen;
  logic [DUP_W-1:0]    duplicate_count;
  logic [WIN_W-1:0]    congestion_window;
  rtt_est_t            rtt_est;
  logic                rtt_seeded;

  // input register
  logic                in_full;
  logic [SEQ_W-1:0]    ack_q;
  logic [RTT_W-1:0]    rtt_q;

  logic                in_take;
  logic                advance;

  // step logic
  logic [SEQ_W-1:0]    gap;
  logic                is_new;
  logic                is_dup;
  logic [DUP_W-1:0]    dup_bumped;
  logic [SEQ_W-1:0]    ack_plus_one;
  logic [SEQ_W-1:0]    win_inc;
  logic [SEQ_W:0]      win_sum;
  logic [WIN_W-1:0]    win_added;
  rtt_est_t            rtt_est_calc;

  logic [KIND_W-1:0]   kind_next;
  logic [SEQ_W-1:0]    resend_next;
  logic [WIN_W-1:0]    released_next;
  logic [SEQ_W-1:0]    unacked_base_next;
  logic [SEQ_W-1:0]    last_ack_seen_next;
  logic [DUP_W-1:0]    duplicate_count_next;
  logic [WIN_W-1:0]    congestion_window_next;
  rtt_est_t            rtt_est_next;
  logic                rtt_seeded_next;

  // handshake: the held ack moves into the result register whenever that
  // register is empty or its result is being taken this cycle
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ack_q <= ack_number;
      rtt_q <= rtt_sample;
    end
  end

  // sequence distance, positive means the ack moves the base forward
  assign gap          = ack_q - unacked_base + 32'd1;
  assign is_new       = (gap != '0) && !gap[SEQ_W-1];
  assign is_dup       = !is_new && (ack_q == last_ack_seen);
  assign ack_plus_one = ack_q + 32'd1;
  assign dup_bumped   = (duplicate_count < DUP_THRESHOLD) ? duplicate_count + 2'd1
                                                          : duplicate_count;

  // window increment: the whole gap in slow start, otherwise one
  assign win_inc   = (is_new && (congestion_window < slow_start_threshold)) ? gap : 32'd1;
  assign win_sum   = {1'b0, win_inc} + (SEQ_W+1)'(congestion_window);
  assign win_added = (|win_sum[SEQ_W:WIN_W]) ? WIN_MAX : win_sum[WIN_W-1:0];

  tawru_rtt_calc u_rtt_calc (
    .rtt_sample      (rtt_q),
    .seeded          (rtt_seeded),
    .est_cur         (rtt_est),
    .alpha_gain      (alpha_gain),
    .beta_gain       (beta_gain),
    .variance_offset (variance_offset),
    .est_next        (rtt_est_calc)
  );

  always_comb begin
    kind_next              = KIND_STALE;
    resend_next            = '0;
    released_next          = '0;
    unacked_base_next      = unacked_base;
    last_ack_seen_next     = last_ack_seen;
    duplicate_count_next   = duplicate_count;
    congestion_window_next = congestion_window;
    rtt_est_next           = rtt_est;
    rtt_seeded_next        = rtt_seeded;
    priority if (is_new) begin
      kind_next              = KIND_NEW_ACK;
      released_next          = (|gap[SEQ_W-1:WIN_W]) ? WIN_MAX : gap[WIN_W-1:0];
      last_ack_seen_next     = ack_q;
      duplicate_count_next   = '0;
      rtt_est_next           = rtt_est_calc;
      rtt_seeded_next        = 1'b1;
      congestion_window_next = win_added;
      unacked_base_next      = ack_plus_one;
    end else if (is_dup) begin
      duplicate_count_next = dup_bumped;
      if (dup_bumped >= DUP_THRESHOLD) begin
        // third repeat and every one after it
        kind_next              = KIND_RETRANSMIT;
        resend_next            = ack_plus_one;
        congestion_window_next = win_added;
      end else begin
        kind_next = KIND_DUPLICATE;
      end
    end else begin
      // stale ack, nothing changes
      kind_next = KIND_STALE;
    end
  end

  // state and configuration; the user must write config only while idle, not enforced here
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain           <= 9'd32;
      beta_gain            <= 9'd64;
      variance_offset      <= '0;
      slow_start_threshold <= 16'd64;
      unacked_base         <= '0;
      last_ack_seen        <= '0;
      duplicate_count      <= '0;
      congestion_window    <= 16'd1;
      rtt_est              <= '0;
      rtt_seeded           <= 1'b0;
    end else begin
      if (advance) begin
        unacked_base      <= unacked_base_next;
        last_ack_seen     <= last_ack_seen_next;
        duplicate_count   <= duplicate_count_next;
        congestion_window <= congestion_window_next;
        rtt_est           <= rtt_est_next;
        rtt_seeded        <= rtt_seeded_next;
      end
      if (cfg_write_enable) begin
        unique case (cfg_index)
          REG_ALPHA_GAIN:     alpha_gain           <= cfg_data[GAIN_W-1:0];
          REG_BETA_GAIN:      beta_gain            <= cfg_data[GAIN_W-1:0];
          REG_VARIANCE_OFS:   variance_offset      <= cfg_data[OFFSET_W-1:0];
          REG_SSTHRESH:       slow_start_threshold <= cfg_data[WIN_W-1:0];
          // the initial values only ever load live state, no read-back
          REG_INITIAL_WINDOW: congestion_window    <= cfg_data[WIN_W-1:0];
          REG_INITIAL_SEQ:    unacked_base         <= cfg_data[SEQ_W-1:0];
          default: begin
            // unused index, write dropped
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ack_kind            <= kind_next;
      retransmit_sequence <= resend_next;
      released_count      <= released_next;
      oldest_unacked      <= unacked_base_next;
      window_now          <= congestion_window_next;
      smoothed_rtt        <= rtt_est_next.srtt;
      rtt_variance        <= rtt_est_next.rttvar;
    end
  end

endmodule

[bench/testbench.sv]
// self-checking bench for tcp_ack_window_rtt_update_unit: ack stream in, result stream out
// depends on tawru_pkg and the unit under test, nothing else
`timescale 1ns / 1ps

module testbench;
  import tawru_pkg::*;

  // one ack transfer as queued for the driver
  typedef struct packed {
    logic [31:0] ack;
    logic [31:0] rtt;
  } ack_item_t;

  // one result transfer as the predictor expects it
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] resend;
    logic [15:0] released;
    logic [31:0] oldest;
    logic [15:0] window;
    logic [31:0] srtt;
    logic [31:0] rttvar;
  } ack_outcome_t;

  localparam int STALL_PCT   = 15;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int RANDOM_PHASES   = 8;

  // every input has a known value from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] ack_number = '0;
  logic [31:0] rtt_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  ack_kind;
  logic [31:0] retransmit_sequence;
  logic [15:0] released_count;
  logic [31:0] oldest_unacked;
  logic [15:0] window_now;
  logic [31:0] smoothed_rtt;
  logic [31:0] rtt_variance;

  tcp_ack_window_rtt_update_unit uut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write_enable    (cfg_write_enable),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .ack_number          (ack_number),
    .rtt_sample          (rtt_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .ack_kind            (ack_kind),
    .retransmit_sequence (retransmit_sequence),
    .released_count      (released_count),
    .oldest_unacked      (oldest_unacked),
    .window_now          (window_now),
    .smoothed_rtt        (smoothed_rtt),
    .rtt_variance        (rtt_variance)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: registers and live sender state, at reset values
  // ---------------------------------------------------------------------------
  logic [8:0]  alpha_q   = 9'd32;
  logic [8:0]  beta_q    = 9'd64;
  logic [15:0] var_ofs   = 16'd0;
  logic [15:0] ssthresh  = 16'd64;
  logic [31:0] base_seq  = 32'd0;
  logic [31:0] last_ack  = 32'd0;
  logic [1:0]  dup_cnt   = 2'd0;
  logic [15:0] cwnd      = 16'd1;
  logic [31:0] srtt_est  = 32'd0;
  logic [31:0] rttvar_est = 32'd0;
  logic        seeded    = 1'b0;

  // stimulus side tracking of base and last ack, so sequences can be aimed
  logic [31:0] gen_base = 32'd0;
  logic [31:0] gen_last = 32'd0;

  ack_item_t    acks_to_send[$];
  ack_outcome_t ack_outcomes_due[$];
  int           acks_queued = 0;
  int           acks_taken = 0;
  int           mismatches = 0;
  int           cyc = 0;
  int           quiet_cycles = 0;
  ack_item_t    cur_ack;
  ack_outcome_t next_outcome;
  ack_outcome_t want;

  // calm window of the cycle counter: no random idling and no output stalls
  wire calm = (cyc % 1500) >= 1100;

  function automatic logic [15:0] sat_window(input logic [15:0] w, input logic [31:0] inc);
    logic [32:0] sum;
    sum = {17'd0, w} + {1'b0, inc};
    return (sum > 33'hFFFF) ? WIN_MAX : sum[15:0];
  endfunction

  // jacobson estimator, variance taken against the old srtt
  task automatic update_rtt(input logic [31:0] rtt);
    logic [8:0]  a;
    logic [8:0]  b;
    logic [31:0] d;
    logic [63:0] v;
    logic [63:0] s;
    if (!seeded) begin
      srtt_est = rtt;
      rttvar_est = rtt >> 1;
      seeded = 1'b1;
    end else begin
      // gains above one are treated as one
      a = (alpha_q > GAIN_ONE) ? GAIN_ONE : alpha_q;
      b = (beta_q > GAIN_ONE) ? GAIN_ONE : beta_q;
      d = (srtt_est > rtt) ? srtt_est - rtt : rtt - srtt_est;
      v = ((64'(GAIN_ONE - b) * rttvar_est + 64'(b) * d) >> 8) + 64'(var_ofs);
      s = (64'(GAIN_ONE - a) * srtt_est + 64'(a) * rtt) >> 8;
      rttvar_est = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      srtt_est = s[31:0];
    end
  endtask

  // classify one accepted ack and advance the sender state
  task automatic classify_ack(input logic [31:0] ack, input logic [31:0] rtt,
                              output ack_outcome_t res);
    logic [31:0] gap;
    gap = ack - base_seq + 32'd1;
    res = '0;
    res.kind = KIND_STALE;
    if (gap != 32'd0 && !gap[31]) begin
      res.kind = KIND_NEW_ACK;
      res.released = (gap > 32'hFFFF) ? WIN_MAX : gap[15:0];
      last_ack = ack;
      dup_cnt = 2'd0;
      update_rtt(rtt);
      // slow start grows by the gap, congestion avoidance by one
      cwnd = (cwnd < ssthresh) ? sat_window(cwnd, gap) : sat_window(cwnd, 32'd1);
      base_seq = ack + 32'd1;
    end else if (ack == last_ack) begin
      // count saturates, so every repeat past the threshold resends again
      if (dup_cnt < DUP_THRESHOLD) dup_cnt = dup_cnt + 2'd1;
      if (dup_cnt == DUP_THRESHOLD) begin
        res.kind = KIND_RETRANSMIT;
        res.resend = ack + 32'd1;
        cwnd = sat_window(cwnd, 32'd1);
      end else begin
        res.kind = KIND_DUPLICATE;
      end
    end
    res.oldest = base_seq;
    res.window = cwnd;
    res.srtt = srtt_est;
    res.rttvar = rttvar_est;
  endtask

  // register write as the unit sees it; the initial loads take effect at once
  task automatic apply_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      REG_ALPHA_GAIN: alpha_q = val[8:0];
      REG_BETA_GAIN: beta_q = val[8:0];
      REG_VARIANCE_OFS: var_ofs = val[15:0];
      REG_SSTHRESH: ssthresh = val[15:0];
      REG_INITIAL_WINDOW: cwnd = val[15:0];
      REG_INITIAL_SEQ: base_seq = val;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: config writes and ack transfers; prediction happens on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_write_enable) apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        classify_ack(ack_number, rtt_sample, next_outcome);
        ack_outcomes_due.push_back(next_outcome);
        acks_taken++;
      end
      // a stalled transfer holds its payload; otherwise load the next or idle
      if (!in_valid || !in_stall) begin
        if (acks_to_send.size() != 0 && (calm || $urandom_range(99) >= STALL_PCT)) begin
          cur_ack = acks_to_send.pop_front();
          in_valid <= 1'b1;
          ack_number <= cur_ack.ack;
          rtt_sample <= cur_ack.rtt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each result transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (ack_outcomes_due.size() == 0) begin
          $error("result transfer with no ack outstanding");
          mismatches++;
        end else begin
          want = ack_outcomes_due.pop_front();
          check_field("ack_kind", 32'(want.kind), 32'(ack_kind));
          check_field("retransmit_sequence", want.resend, retransmit_sequence);
          check_field("released_count", 32'(want.released), 32'(released_count));
          check_field("oldest_unacked", want.oldest, oldest_unacked);
          check_field("window_now", 32'(want.window), 32'(window_now));
          check_field("smoothed_rtt", want.srtt, smoothed_rtt);
          check_field("rtt_variance", want.rttvar, rtt_variance);
        end
      end
      out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
    end
  end

  // watchdog: too long without any transfer or write means a hang
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_enable) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // consecutive writes keep the enable high; end_writes drops it
  task automatic put_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_INITIAL_SEQ) gen_base = val;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  // queue one ack; counted is low when the unit will just ignore it as stale
  task automatic queue_ack(input logic [31:0] ack, input logic [31:0] rtt, output bit counted);
    logic [31:0] gap;
    ack_item_t   item;
    gap = ack - gen_base + 32'd1;
    counted = 1'b1;
    if (gap != 32'd0 && !gap[31]) begin
      gen_base = ack + 32'd1;
      gen_last = ack;
    end else if (ack != gen_last) begin
      counted = 1'b0;
    end
    item.ack = ack;
    item.rtt = rtt;
    acks_to_send.push_back(item);
    acks_queued++;
  endtask

  // wait until every queued ack has its result, then let the pipe settle
  task automatic drain_acks();
    do @(negedge clk);
    while (acks_taken != acks_queued || ack_outcomes_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // mostly small gaps, some past the release counter, a few at the sign limit
  function automatic logic [31:0] pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(16, 1);
    if (roll < 90) return $urandom_range(70000, 1);
    if (roll < 97) return $urandom_range(32'h7FFF_FFFF, 1);
    return 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] pick_rtt();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom_range(200000, 1000);
    if (roll < 93) return $urandom;
    if (roll < 97) return 32'd0;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'd256;
      2: return $urandom_range(511, 257);
      default: return $urandom_range(256, 0);
    endcase
  endfunction

  // new settings between phases; each register written about half the time
  task automatic shuffle_config();
    logic [31:0] v;
    if ($urandom_range(1)) put_reg(REG_ALPHA_GAIN, pick_gain());
    if ($urandom_range(1)) put_reg(REG_BETA_GAIN, pick_gain());
    if ($urandom_range(1)) begin
      case ($urandom_range(3))
        0: v = 32'd0;
        1: v = 32'd65535;
        2: v = $urandom_range(4000, 0);
        default: v = $urandom_range(65535, 0);
      endcase
      put_reg(REG_VARIANCE_OFS, v);
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(2))
        0: v = 32'd1;
        1: v = 32'd65535;
        default: v = $urandom_range(200, 1);
      endcase
      put_reg(REG_SSTHRESH, v);
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(2))
        0: v = 32'd1;
        1: v = 32'd65535;
        default: v = $urandom_range(100, 1);
      endcase
      put_reg(REG_INITIAL_WINDOW, v);
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(3))
        0: v = 32'd0;
        1: v = 32'hFFFF_FFFF;
        2: v = 32'hFFFF_FF00 + $urandom_range(255, 0);
        default: v = $urandom;
      endcase
      put_reg(REG_INITIAL_SEQ, v);
    end
    end_writes();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    int taken;
    int roll;
    int runs;
    bit hit;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // right after reset last ack is zero: move the base so ack 0 is a repeat
    put_reg(REG_INITIAL_SEQ, 32'd5);
    end_writes();
    repeat (4) queue_ack(32'd0, 32'd100, hit);   // two duplicates, then resends
    queue_ack(32'd3, 32'd7, hit);                // behind the base
    queue_ack(32'd4, 32'd7, hit);                // zero gap, not the last ack
    queue_ack(32'hFFFF_FFFF, 32'd7, hit);
    // largest positive gap: release and window saturate, first sample seeds
    queue_ack(gen_base + 32'h7FFF_FFFE, 32'hFFFF_FFFF, hit);
    // gap of exactly 2^31 reads as negative
    queue_ack(gen_base + 32'h7FFF_FFFF, 32'd5, hit);
    repeat (3) queue_ack(gen_last, 32'd9, hit);
    queue_ack(gen_base, 32'd0, hit);
    queue_ack(gen_base, 32'hFFFF_FFFF, hit);
    drain_acks();

    // gains above one, widest offset, sequence wraps through zero
    put_reg(REG_ALPHA_GAIN, 32'd511);
    put_reg(REG_BETA_GAIN, 32'd511);
    put_reg(REG_VARIANCE_OFS, 32'd65535);
    put_reg(REG_SSTHRESH, 32'd65535);
    put_reg(REG_INITIAL_WINDOW, 32'd1);
    put_reg(REG_INITIAL_SEQ, 32'hFFFF_FFF0);
    end_writes();
    queue_ack(gen_base + 32'd5, 32'hFFFF_FFFF, hit);
    queue_ack(gen_base + 32'd12, 32'd0, hit);    // variance saturates
    queue_ack(gen_last, 32'd1, hit);
    queue_ack(gen_base + 32'hFFFF, 32'd50, hit); // release just past 16 bits
    drain_acks();

    // zero gains, threshold of one, full initial window
    put_reg(REG_ALPHA_GAIN, 32'd0);
    put_reg(REG_BETA_GAIN, 32'd0);
    put_reg(REG_VARIANCE_OFS, 32'd0);
    put_reg(REG_SSTHRESH, 32'd1);
    put_reg(REG_INITIAL_WINDOW, 32'd65535);
    put_reg(REG_INITIAL_SEQ, 32'hFFFF_FFFF);
    end_writes();
    queue_ack(gen_base, 32'd1234, hit);
    queue_ack(gen_base + 32'd65533, 32'd42, hit);
    repeat (2) queue_ack(gen_last, 32'd77, hit);
    drain_acks();

    // random phases: mostly aimed new acks and duplicate runs, some noise
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      shuffle_config();
      taken = 0;
      while (taken < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 45) begin
          queue_ack(gen_base + pick_gap() - 32'd1, pick_rtt(), hit);
          taken += hit;
        end else if (roll < 75) begin
          runs = $urandom_range(6, 1);
          repeat (runs) begin
            queue_ack(gen_last, pick_rtt(), hit);
            taken += hit;
          end
        end else if (roll < 88) begin
          if ($urandom_range(1))
            queue_ack(gen_base - 32'd2 - $urandom_range(2000, 0), pick_rtt(), hit);
          else
            queue_ack(gen_base + 32'h8000_0000 + $urandom_range(1000, 0), pick_rtt(), hit);
          taken += hit;
        end else begin
          queue_ack($urandom, $urandom, hit);
          taken += hit;
        end
      end
      drain_acks();
    end

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
